// File: hw/rtl/bed_pkg.sv
package bed_pkg;

   // Border geometry and coordinate space.
   localparam int MAX_BORDER = 64;
   localparam int MAP_SIZE   = 1024;
   localparam int POS_W      = 7;
   localparam int COORD_W    = 10;
   localparam int THR_W      = 7;

   // Configuration port.
   localparam int CSR_W     = 10;
   localparam int CSR_IDX_W = 3;

   // Job queue between the front and the back.
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   // Step of minus one in the wrapped coordinate space.
   localparam logic [COORD_W-1:0] BACK_STEP = COORD_W'(MAP_SIZE - 1);

   // Last position along a border.
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_BORDER - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_ORIENT    = 3'd1,
      CSR_START_X   = 3'd2,
      CSR_START_Y   = 3'd3,
      CSR_MAP_EDGE  = 3'd4
   } csr_index_type;

   typedef enum logic {
      ORIENT_EAST  = 1'b0,
      ORIENT_SOUTH = 1'b1
   } orient_type;

   typedef struct packed {
      logic [THR_W-1:0]   threshold;
      orient_type         orientation;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic               at_map_edge;
   } cfg_type;

   // One closed run: where its transitions lie and whether there are two.
   typedef struct packed {
      logic             two;
      logic [POS_W-1:0] pos0;
      logic [POS_W-1:0] pos1;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: hw/rtl/bed_front.sv
module bed_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             inside_open,
   input  logic             outside_open,
   input  logic             last_cell,
   input  bed_pkg::cfg_type cfg,
   output logic             job_push,
   output bed_pkg::job_type job
);
   import bed_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] begin_ff, begin_in;
   logic [POS_W-1:0] len_ff, len_in;

   logic             both_open;
   logic             is_last;
   logic             closes;
   logic [POS_W-1:0] len_new;
   logic [POS_W-1:0] begin_new;

   // Classify the word: does it extend the open run, and does the run close here.
   always_comb begin
      both_open = inside_open && outside_open;
      is_last   = last_cell || (pos_ff >= LAST_POS);
      len_new   = both_open ? POS_W'(len_ff + 1'b1) : len_ff;
      begin_new = (both_open && (len_ff == '0)) ? pos_ff : begin_ff;
      closes    = (!both_open || is_last) && (len_new != '0);
   end

   // Place the transitions of a closing run.
   always_comb begin
      job.two  = (len_new >= cfg.threshold);
      job.pos1 = POS_W'(begin_new + len_new - 1'b1);
      if (job.two) begin
         job.pos0 = begin_new;
      end else begin
         job.pos0 = POS_W'(begin_new + (len_new >> 1));
      end
      job_push = accept && closes && !cfg.at_map_edge;
   end

   // Scan state update.
   always_comb begin
      pos_in   = pos_ff;
      begin_in = begin_ff;
      len_in   = len_ff;
      if (accept) begin
         if (is_last) begin
            pos_in   = '0;
            begin_in = '0;
            len_in   = '0;
         end else begin
            pos_in = POS_W'(pos_ff + 1'b1);
            if (closes) begin
               begin_in = '0;
               len_in   = '0;
            end else begin
               begin_in = begin_new;
               len_in   = len_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         begin_ff <= '0;
         len_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         len_ff   <= len_in;
      end
   end

endmodule

// File: hw/rtl/bed_job_queue.sv
module bed_job_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_job,
   input  bed_pkg::job_type          push_data,
   input  logic                      pop_job,
   output bed_pkg::job_type          head,
   output bed_pkg::queue_status_type status
);
   import bed_pkg::*;

   job_type              entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   // Pointer and fill count bookkeeping.
   always_comb begin
      status.full  = (count_ff == JOB_CNT_W'(JOB_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push_job && !status.full;
      do_pop       = pop_job && !status.empty;
      wr_ptr_in    = do_push ? JOB_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? JOB_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = JOB_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = JOB_CNT_W'(count_ff - 1'b1);
      end
      head = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The front never offers a job into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push_job)
      else $error("job pushed into a full queue");

   // Pointers stay consistent with the fill count.
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == JOB_CNT_W'(JOB_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

endmodule

// File: hw/rtl/bed_back.sv
module bed_back (
   input  logic                           clock,
   input  logic                           reset,
   input  bed_pkg::cfg_type               cfg,
   input  bed_pkg::job_type               job,
   input  bed_pkg::queue_status_type      status,
   output logic                           pop_job,
   input  logic                           pop,
   output logic                           empty,
   output logic [bed_pkg::COORD_W-1:0]    outside_x,
   output logic [bed_pkg::COORD_W-1:0]    outside_y,
   output logic [bed_pkg::COORD_W-1:0]    inside_x,
   output logic [bed_pkg::COORD_W-1:0]    inside_y,
   output logic                           last_result
);
   import bed_pkg::*;

   logic               valid_ff, valid_in;
   logic               half_ff, half_in;
   logic [COORD_W-1:0] out_x_ff, out_x_in;
   logic [COORD_W-1:0] out_y_ff, out_y_in;
   logic [COORD_W-1:0] in_x_ff, in_x_in;
   logic [COORD_W-1:0] in_y_ff, in_y_in;
   logic               last_ff, last_in;

   logic               load;
   logic               issue;
   logic [POS_W-1:0]   sel_pos;
   logic [COORD_W-1:0] along;

   // Issue one word from the head job whenever the output register frees up and a job waits.
   always_comb begin
      load     = !valid_ff || pop;
      issue    = load && !status.empty;
      sel_pos  = half_ff ? job.pos1 : job.pos0;
      last_in  = !job.two || half_ff;
      pop_job  = issue && last_in;
      half_in  = issue ? (job.two && !half_ff) : half_ff;
      valid_in = issue ? 1'b1 : (pop ? 1'b0 : valid_ff);
   end

   // Coordinates of both endpoints, wrapped to the map.
   always_comb begin
      if (cfg.orientation == ORIENT_EAST) begin
         along    = COORD_W'(cfg.start_y + COORD_W'(sel_pos));
         out_x_in = cfg.start_x;
         out_y_in = along;
         in_x_in  = COORD_W'(cfg.start_x + BACK_STEP);
         in_y_in  = along;
      end else begin
         along    = COORD_W'(cfg.start_x + COORD_W'(sel_pos));
         out_x_in = along;
         out_y_in = cfg.start_y;
         in_x_in  = along;
         in_y_in  = COORD_W'(cfg.start_y + BACK_STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         in_x_ff  <= in_x_in;
         in_y_ff  <= in_y_in;
         last_ff  <= last_in;
      end
   end

   assign empty       = !valid_ff;
   assign outside_x   = out_x_ff;
   assign outside_y   = out_y_ff;
   assign inside_x    = in_x_ff;
   assign inside_y    = in_y_ff;
   assign last_result = last_ff;

   // A job whose first word went out stays at the head of the queue.
   a_half_keeps_job: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> !status.empty)
      else $error("second word pending without its job");

   // While the second word is pending, the first one is in the output register.
   a_half_has_word: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> valid_ff)
      else $error("second word pending with an empty output register");

endmodule

// File: hw/rtl/border_entrance_detector.sv
// Channel   Handshake            Payload
// request   push / full          req_inside_open, req_outside_open, req_last_cell
// response  pop / empty          rsp_outside_x/y, rsp_inside_x/y, rsp_last_result
// config    csr_we               csr_index, csr_wdata
//
// One cell word is accepted each cycle while full is low; a closing run becomes
// a job in a four-entry queue unless the map edge is set; the back turns a job
// into one or two words. A first word goes through the queue entry and then the
// output register to the response ports; a second word follows through the same
// output register. Full rises once four jobs wait, under a stalled pop or when
// two-word runs outpace the output register. Reset is synchronous and active high.
module border_entrance_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_inside_open,
   input  logic                               req_outside_open,
   input  logic                               req_last_cell,
   output logic                               empty,
   input  logic                               pop,
   output logic [bed_pkg::COORD_W-1:0]        rsp_outside_x,
   output logic [bed_pkg::COORD_W-1:0]        rsp_outside_y,
   output logic [bed_pkg::COORD_W-1:0]        rsp_inside_x,
   output logic [bed_pkg::COORD_W-1:0]        rsp_inside_y,
   output logic                               rsp_last_result,
   input  logic                               csr_we,
   input  logic [bed_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bed_pkg::CSR_W-1:0]          csr_wdata
);
   import bed_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             accept;
   logic             job_push;
   logic             pop_job;
   job_type          new_job;
   job_type          head_job;
   queue_status_type status;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD: cfg_in.threshold   = csr_wdata[THR_W-1:0];
            CSR_ORIENT:    cfg_in.orientation = orient_type'(csr_wdata[0]);
            CSR_START_X:   cfg_in.start_x     = csr_wdata[COORD_W-1:0];
            CSR_START_Y:   cfg_in.start_y     = csr_wdata[COORD_W-1:0];
            CSR_MAP_EDGE:  cfg_in.at_map_edge = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= THR_W'(6);
         cfg_ff.orientation <= ORIENT_EAST;
         cfg_ff.start_x     <= '0;
         cfg_ff.start_y     <= '0;
         cfg_ff.at_map_edge <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A word is taken whenever the job queue has room.
   assign full   = status.full;
   assign accept = push && !status.full;

   bed_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .inside_open  (req_inside_open),
      .outside_open (req_outside_open),
      .last_cell    (req_last_cell),
      .cfg          (cfg_ff),
      .job_push     (job_push),
      .job          (new_job)
   );

   bed_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_job  (job_push),
      .push_data (new_job),
      .pop_job   (pop_job),
      .head      (head_job),
      .status    (status)
   );

   bed_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .job         (head_job),
      .status      (status),
      .pop_job     (pop_job),
      .pop         (pop),
      .empty       (empty),
      .outside_x   (rsp_outside_x),
      .outside_y   (rsp_outside_y),
      .inside_x    (rsp_inside_x),
      .inside_y    (rsp_inside_y),
      .last_result (rsp_last_result)
   );

endmodule

// File: verif/tb_border_entrance_detector.sv
`timescale 1ns / 100ps

module tb_border_entrance_detector;
   import bed_pkg::*;

   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 400;
   localparam int REPORT_LIMIT   = 10;

   // One transition pair as it appears on the response ports.
   typedef struct packed {
      logic [COORD_W-1:0] outside_x;
      logic [COORD_W-1:0] outside_y;
      logic [COORD_W-1:0] inside_x;
      logic [COORD_W-1:0] inside_y;
      logic               last_result;
   } transition_type;

   // One border cell word; typed_count below zero leaves the expectation to the predictor.
   typedef struct {
      logic           inside_open;
      logic           outside_open;
      logic           last_cell;
      int             typed_count;
      transition_type typed_first;
      transition_type typed_second;
   } cell_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic                 req_inside_open = 1'b0;
   logic                 req_outside_open = 1'b0;
   logic                 req_last_cell = 1'b0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [COORD_W-1:0]   rsp_outside_x;
   logic [COORD_W-1:0]   rsp_outside_y;
   logic [COORD_W-1:0]   rsp_inside_x;
   logic [COORD_W-1:0]   rsp_inside_y;
   logic                 rsp_last_result;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Typed expectation that travels with the word on the request ports.
   int             row_typed_count = -1;
   transition_type row_typed_first = '0;
   transition_type row_typed_second = '0;

   // Predictor copy of the registers and of the scan state.
   logic [THR_W-1:0]   run_threshold = THR_W'(6);
   orient_type         scan_dir = ORIENT_EAST;
   logic [COORD_W-1:0] border_x = '0;
   logic [COORD_W-1:0] border_y = '0;
   logic               edge_mute = 1'b0;
   logic [POS_W-1:0]   scan_pos = '0;
   logic [POS_W-1:0]   open_begin = '0;
   logic [POS_W-1:0]   open_len = '0;

   transition_type pending_transitions[$];
   int             mismatches = 0;
   int             quiet_cycles = 0;
   int             cells_sent = 0;
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             rsp_hold_left = 0;

   // Directed scans under the reset configuration: eastern border at the origin.
   cell_row_type directed_rows[24] = '{
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b0, 1'b0, 1'b0, 1, '{10'd0, 10'd0, 10'd1023, 10'd0, 1'b1}, '0},
      '{1'b1, 1'b0, 1'b0, 0, '0, '0},
      '{1'b0, 1'b1, 1'b0, 0, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b0, 1'b1, 1'b0, 2, '{10'd0, 10'd4, 10'd1023, 10'd4, 1'b0},
                              '{10'd0, 10'd9, 10'd1023, 10'd9, 1'b1}},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b1, -1, '0, '0},
      '{1'b1, 1'b1, 1'b1, 1, '{10'd0, 10'd0, 10'd1023, 10'd0, 1'b1}, '0},
      '{1'b0, 1'b0, 1'b1, 0, '0, '0},
      '{1'b1, 1'b0, 1'b1, 0, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b1, 1'b1, 1'b0, -1, '0, '0},
      '{1'b0, 1'b0, 1'b1, -1, '0, '0}
   };

   border_entrance_detector dut (.*);

   always #10 clock = ~clock;

   // Place one transition at a border position under the current registers.
   function automatic transition_type place_transition(logic [POS_W-1:0] pos, logic last_one);
      transition_type     t;
      logic [COORD_W-1:0] step;
      step = COORD_W'(pos);
      if (scan_dir == ORIENT_EAST) begin
         t.outside_x = border_x;
         t.outside_y = border_y + step;
         t.inside_x  = border_x - 1'b1;
         t.inside_y  = border_y + step;
      end else begin
         t.outside_x = border_x + step;
         t.outside_y = border_y;
         t.inside_x  = border_x + step;
         t.inside_y  = border_y - 1'b1;
      end
      t.last_result = last_one;
      return t;
   endfunction

   // Advance the scan by one cell and work out the transitions it closes.
   task automatic trace_border_cell(input logic in_open, input logic out_open,
                                    input logic end_mark, output transition_type first,
                                    output transition_type second, output int count);
      logic both_open;
      logic final_cell;
      both_open  = in_open && out_open;
      final_cell = end_mark || (scan_pos >= POS_W'(MAX_BORDER - 1));
      count  = 0;
      first  = '0;
      second = '0;
      if (both_open) begin
         if (open_len == 0) open_begin = scan_pos;
         open_len = open_len + 1'b1;
      end
      if ((!both_open || final_cell) && open_len != 0) begin
         if (!edge_mute) begin
            if (open_len >= run_threshold) begin
               first  = place_transition(open_begin, 1'b0);
               second = place_transition(open_begin + open_len - 1'b1, 1'b1);
               count  = 2;
            end else begin
               first = place_transition(open_begin + (open_len >> 1), 1'b1);
               count = 1;
            end
         end
         open_len   = '0;
         open_begin = '0;
      end
      if (final_cell) begin
         scan_pos   = '0;
         open_begin = '0;
         open_len   = '0;
      end else begin
         scan_pos = scan_pos + 1'b1;
      end
   endtask

   // Follow register writes, accepted cell words and accepted result words.
   always @(posedge clock) begin
      transition_type first;
      transition_type second;
      transition_type want;
      transition_type got;
      int             count;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_THRESHOLD: run_threshold = csr_wdata[THR_W-1:0];
               CSR_ORIENT:    scan_dir = orient_type'(csr_wdata[0]);
               CSR_START_X:   border_x = csr_wdata[COORD_W-1:0];
               CSR_START_Y:   border_y = csr_wdata[COORD_W-1:0];
               CSR_MAP_EDGE:  edge_mute = csr_wdata[0];
               default: ;
            endcase
         end
         if (push && !full) begin
            trace_border_cell(req_inside_open, req_outside_open, req_last_cell,
                              first, second, count);
            if (row_typed_count >= 0) begin
               count  = row_typed_count;
               first  = row_typed_first;
               second = row_typed_second;
            end
            if (count > 0) pending_transitions.push_back(first);
            if (count > 1) pending_transitions.push_back(second);
         end
         if (pop && !empty) begin
            got = '{rsp_outside_x, rsp_outside_y, rsp_inside_x, rsp_inside_y,
                    rsp_last_result};
            if (pending_transitions.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected word: ox=%0d oy=%0d ix=%0d iy=%0d last=%0b",
                           got.outside_x, got.outside_y, got.inside_x, got.inside_y,
                           got.last_result);
            end else begin
               want = pending_transitions.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"mismatch: expected ox=%0d oy=%0d ix=%0d iy=%0d last=%0b,",
                               " got ox=%0d oy=%0d ix=%0d iy=%0d last=%0b"},
                              want.outside_x, want.outside_y, want.inside_x,
                              want.inside_y, want.last_result, got.outside_x,
                              got.outside_y, got.inside_x, got.inside_y,
                              got.last_result);
               end
            end
         end
      end
   end

   // Watchdog on cycles in which no word moves on either side.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Result side: random stalls, or a counted hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one cell word and wait until the block takes it.
   task automatic offer_cell(input cell_row_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push             <= 1'b1;
      req_inside_open  <= c.inside_open;
      req_outside_open <= c.outside_open;
      req_last_cell    <= c.last_cell;
      row_typed_count  <= c.typed_count;
      row_typed_first  <= c.typed_first;
      row_typed_second <= c.typed_second;
      @(posedge clock);
      while (full) @(posedge clock);
      cells_sent++;
   endtask

   function automatic cell_row_type make_cell(logic in_open, logic out_open, logic end_mark);
      cell_row_type c;
      c = '{in_open, out_open, end_mark, -1, '0, '0};
      return c;
   endfunction

   // One border scan: open runs of random length split by blocked pairs.
   // Now and then the scan runs the full longest border without an end mark.
   task automatic offer_scan();
      int   len;
      int   run_left;
      int   kind;
      logic overlong;
      overlong = ($urandom_range(19) == 0);
      if (overlong) len = MAX_BORDER;
      else if ($urandom_range(7) == 0) len = $urandom_range(MAX_BORDER, 17);
      else len = $urandom_range(16, 1);
      run_left = 0;
      for (int i = 0; i < len; i++) begin
         if (run_left == 0 && $urandom_range(99) < 55)
            run_left = $urandom_range(($urandom_range(3) == 0) ? 40 : 8, 1);
         if (run_left != 0) begin
            run_left--;
            offer_cell(make_cell(1'b1, 1'b1, (i == len - 1) && !overlong));
         end else begin
            kind = $urandom_range(2);
            offer_cell(make_cell(kind == 1, kind == 2, (i == len - 1) && !overlong));
         end
      end
   endtask

   // Random part of a phase; it ends inside an open run so that the next
   // register settings apply to a run already under way.
   task automatic run_phase(int count);
      int stop;
      stop = cells_sent + count;
      while (cells_sent < stop) begin
         if ($urandom_range(9) == 0)
            offer_cell(make_cell(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 $urandom_range(7) == 0));
         else
            offer_scan();
      end
      offer_cell(make_cell(1'b1, 1'b1, 1'b0));
      offer_cell(make_cell(1'b1, 1'b1, 1'b0));
   endtask

   // Stop sending and wait until every expected word has come back.
   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (pending_transitions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(csr_index_type idx, int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
   endtask

   task automatic set_config(int unsigned threshold, orient_type dir, int unsigned sx,
                             int unsigned sy, logic on_edge);
      put_reg(CSR_THRESHOLD, threshold);
      put_reg(CSR_ORIENT, dir);
      put_reg(CSR_START_X, sx);
      put_reg(CSR_START_Y, sy);
      put_reg(CSR_MAP_EDGE, on_edge);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows under the reset defaults.
      foreach (directed_rows[i]) offer_cell(directed_rows[i]);
      wait_idle();

      // Southern border at the far x corner, every run split at both ends.
      set_config(1, ORIENT_SOUTH, 1023, 0, 1'b0);
      run_phase(80);
      wait_idle();

      // Threshold zero on the eastern border, y wrapping; sender idles.
      send_idle_pct = 55;
      set_config(0, ORIENT_EAST, 0, 1023, 1'b0);
      run_phase(80);
      wait_idle();

      // Threshold beyond any border: one transition per run; receiver stalls.
      send_idle_pct = 0;
      rsp_stall_pct = 55;
      set_config(127, ORIENT_SOUTH, 1000, 5, 1'b0);
      run_phase(80);
      wait_idle();

      // Longest border threshold, random origin; both sides idle.
      send_idle_pct = 34;
      rsp_stall_pct = 34;
      set_config(64, ORIENT_EAST, $urandom_range(1023), $urandom_range(1023), 1'b0);
      run_phase(80);
      wait_idle();

      // Map edge: the scan advances but nothing comes out.
      set_config($urandom_range(8, 1), orient_type'($urandom_range(1)),
                 $urandom_range(1023), $urandom_range(1023), 1'b1);
      run_phase(80);
      wait_idle();

      // Hold the result side off while short runs pile up, then let it all drain.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_config(6, ORIENT_SOUTH, $urandom_range(1023), $urandom_range(1023), 1'b0);
      rsp_hold_left = HOLD_CYCLES;
      repeat (30) begin
         offer_cell(make_cell(1'b1, 1'b1, 1'b0));
         offer_cell(make_cell(1'b0, 1'($urandom_range(1)), 1'b0));
      end
      push <= 1'b0;
      @(posedge clock);
      while (pending_transitions.size() != 0) @(posedge clock);
      send_idle_pct = 34;
      rsp_stall_pct = 55;
      run_phase(40);

      wait_idle();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
